// File: sv/mrs_pkg.sv
// ============================================================================
// mrs_pkg
// Shared types and constants for the message receive session block.
// ============================================================================
`default_nettype none

package mrs_pkg;

    // text store
    localparam int BUF_CHARS  = 32;
    localparam int BUF_IDX_W  = (BUF_CHARS > 1) ? $clog2(BUF_CHARS) : 1;
    localparam int BUF_CNT_W  = $clog2(BUF_CHARS + 1);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // configuration
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS   = 2'd1;
    localparam logic [19:0] TIMEOUT_TICKS_RESET = 20'd3000;
    localparam logic [15:0] OWN_ADDRESS_RESET   = 16'd0;

    // command codes on the input side
    localparam logic [2:0] CMD_BEGIN    = 3'd0;
    localparam logic [2:0] CMD_PARAM    = 3'd1;
    localparam logic [2:0] CMD_END      = 3'd2;
    localparam logic [2:0] CMD_CONTINUE = 3'd3;
    localparam logic [2:0] CMD_CHECKSUM = 3'd4;
    localparam logic [2:0] CMD_TICK     = 3'd5;

    typedef enum logic [2:0] {
        OP_BEGIN    = 3'd0,
        OP_PARAM    = 3'd1,
        OP_END      = 3'd2,
        OP_CONTINUE = 3'd3,
        OP_CHECKSUM = 3'd4,
        OP_TICK     = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        RK_READY   = 3'd0,
        RK_BUSY    = 3'd1,
        RK_WRONG   = 3'd2,
        RK_TIMEOUT = 3'd3,
        RK_HEADER  = 3'd4,
        RK_CHAR    = 3'd5
    } reply_kind_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] caller_address;
        logic [15:0] char_code;
        logic [16:0] expected_checksum;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  reply_kind;
        logic [15:0] peer_address;
        logic [16:0] reply_value;
        logic [15:0] device_address;
        logic        last_of_run;
    } rsp_item_t;

    // classified operation: argument is caller address, character code or expected checksum
    typedef struct packed {
        op_t         op;
        logic [16:0] arg;
    } op_item_t;

    typedef struct packed {
        logic [19:0] timeout_ticks;
        logic [15:0] own_address;
    } cfg_regs_t;

endpackage

`default_nettype wire

// File: sv/message_receive_session.sv
// ============================================================================
// message_receive_session
// Receiver session for a text message protocol: begin, continue, checksum,
// end and timer handling with replies on a result queue.
// ============================================================================
// Request items are taken one per cycle into a two-entry operation queue as
// long as full is low; unused command codes are accepted and dropped. The
// session engine behind it completes begin, param, continue, checksum and
// tick as each is taken, provided the result register is free. An end item
// loads a header, then, for each of the min(count, 32) stored characters,
// reads the text store into a register and emits the character. Results
// wait in a single output register until popped. Configuration writes are
// always ready and take effect at once.
`default_nettype none

module message_receive_session (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 push,
    output logic                                full,
    input  wire  mrs_pkg::req_item_t            req,
    output logic                                empty,
    input  wire                                 pop,
    output mrs_pkg::rsp_item_t                  rsp,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [mrs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [mrs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    mrs_pkg::cfg_regs_t   cfg_reg;
    mrs_pkg::op_item_t    fq_item, qb_item;
    logic                 fq_push, q_full, q_valid, q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks <= mrs_pkg::TIMEOUT_TICKS_RESET;
            cfg_reg.own_address   <= mrs_pkg::OWN_ADDRESS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mrs_pkg::CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data[19:0];
                mrs_pkg::CFG_OWN_ADDRESS:   cfg_reg.own_address   <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    mrs_front u_front (
        .req    (req),
        .push   (push),
        .full   (full),
        .q_full (q_full),
        .q_push (fq_push),
        .q_item (fq_item)
    );

    mrs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fq_push),
        .push_item (fq_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (qb_item)
    );

    mrs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (qb_item),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

// File: sv/mrs_front.sv
// ============================================================================
// mrs_front
// Takes request items, decodes the command and picks its argument field.
// ============================================================================
`default_nettype none

module mrs_front (
    input  wire  mrs_pkg::req_item_t req,
    input  wire                      push,
    output logic                     full,
    input  wire                      q_full,
    output logic                     q_push,
    output mrs_pkg::op_item_t        q_item
);

    logic known;

    always_comb
    begin
        known      = 1'b1;
        q_item.op  = mrs_pkg::OP_PARAM;
        q_item.arg = '0;
        unique case (req.cmd)
            mrs_pkg::CMD_BEGIN:
            begin
                q_item.op  = mrs_pkg::OP_BEGIN;
                q_item.arg = {1'b0, req.caller_address};
            end
            mrs_pkg::CMD_PARAM:
            begin
                q_item.op = mrs_pkg::OP_PARAM;
            end
            mrs_pkg::CMD_END:
            begin
                q_item.op = mrs_pkg::OP_END;
            end
            mrs_pkg::CMD_CONTINUE:
            begin
                q_item.op  = mrs_pkg::OP_CONTINUE;
                q_item.arg = {1'b0, req.char_code};
            end
            mrs_pkg::CMD_CHECKSUM:
            begin
                q_item.op  = mrs_pkg::OP_CHECKSUM;
                q_item.arg = req.expected_checksum;
            end
            mrs_pkg::CMD_TICK:
            begin
                q_item.op = mrs_pkg::OP_TICK;
            end
            default:
            begin
                known = 1'b0;   // unused codes are dropped
            end
        endcase
    end

    assign full   = q_full;
    assign q_push = push && !q_full && known;

endmodule

`default_nettype wire

// File: sv/mrs_queue.sv
// ============================================================================
// mrs_queue
// Short FIFO of classified operations between front and back.
// ============================================================================
`default_nettype none

module mrs_queue (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      push,
    input  wire  mrs_pkg::op_item_t  push_item,
    output logic                     full,
    input  wire                      pop,
    output logic                     valid,
    output mrs_pkg::op_item_t        pop_item
);

    mrs_pkg::op_item_t                  slot_reg [mrs_pkg::QUEUE_DEPTH];
    logic [mrs_pkg::QUEUE_IDX_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mrs_pkg::QUEUE_IDX_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mrs_pkg::QUEUE_CNT_W-1:0]    count_reg, count_next;
    logic                               do_push, do_pop;

    assign full     = (count_reg == mrs_pkg::QUEUE_CNT_W'(mrs_pkg::QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == mrs_pkg::QUEUE_IDX_W'(mrs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mrs_pkg::QUEUE_IDX_W'(mrs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mrs_pkg::QUEUE_CNT_W'(mrs_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// File: sv/mrs_back.sv
// ============================================================================
// mrs_back
// Session engine: state, checksum, timer, text store and result register.
// ============================================================================
`default_nettype none

module mrs_back (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire  mrs_pkg::cfg_regs_t cfg,
    input  wire                      q_valid,
    input  wire  mrs_pkg::op_item_t  q_item,
    output logic                     q_pop,
    output logic                     empty,
    input  wire                      pop,
    output mrs_pkg::rsp_item_t       rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t                           state_reg, state_next;
    logic                             active_reg, active_next;
    logic [15:0]                      peer_reg, peer_next;
    logic [15:0]                      count_reg, count_next;
    logic [7:0]                       bsum_reg, bsum_next;
    logic [7:0]                       psum_reg, psum_next;
    logic                             armed_reg, armed_next;
    logic [19:0]                      ticks_reg, ticks_next;
    logic [mrs_pkg::BUF_CNT_W-1:0]    drain_len_reg, drain_len_next;
    logic [mrs_pkg::BUF_CNT_W-1:0]    drain_idx_reg, drain_idx_next;
    logic [15:0]                      drain_peer_reg, drain_peer_next;
    logic                             out_valid_reg, out_valid_next;
    mrs_pkg::rsp_item_t               out_reg, out_next;

    logic [15:0]                      text_mem [mrs_pkg::BUF_CHARS];
    logic [15:0]                      rd_data_reg;

    logic                             out_free, take_op, out_load, store_wr;
    logic [mrs_pkg::BUF_CNT_W-1:0]    stored;
    logic [mrs_pkg::BUF_CNT_W-1:0]    idx_inc;
    logic [7:0]                       bs1, ps1, bs2, chk1, chk2;

    assign out_free = !out_valid_reg || pop;
    assign take_op  = (state_reg == S_IDLE) && q_valid && out_free;
    assign q_pop    = take_op;
    assign empty    = !out_valid_reg;
    assign rsp      = out_reg;
    assign store_wr = take_op && (q_item.op == mrs_pkg::OP_CONTINUE)
                    && (count_reg < 16'(mrs_pkg::BUF_CHARS));

    assign stored  = (count_reg < 16'(mrs_pkg::BUF_CHARS))
                   ? count_reg[mrs_pkg::BUF_CNT_W-1:0]
                   : mrs_pkg::BUF_CNT_W'(mrs_pkg::BUF_CHARS);
    assign idx_inc = drain_idx_reg + 1'b1;

    // two bytes per character, high byte first
    assign bs1  = bsum_reg + q_item.arg[15:8];
    assign ps1  = psum_reg + bs1;
    assign bs2  = bs1 + q_item.arg[7:0];
    assign chk2 = bsum_reg + 8'd1;
    assign chk1 = psum_reg + {count_reg[6:0], 1'b0};

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        peer_next       = peer_reg;
        count_next      = count_reg;
        bsum_next       = bsum_reg;
        psum_next       = psum_reg;
        armed_next      = armed_reg;
        ticks_next      = ticks_reg;
        drain_len_next  = drain_len_reg;
        drain_idx_next  = drain_idx_reg;
        drain_peer_next = drain_peer_reg;
        out_load        = 1'b0;
        out_next        = out_reg;
        out_next.device_address = cfg.own_address;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take_op)
                begin
                    unique case (q_item.op)
                        mrs_pkg::OP_BEGIN:
                        begin
                            out_load              = 1'b1;
                            out_next.peer_address = q_item.arg[15:0];
                            out_next.reply_value  = '0;
                            out_next.last_of_run  = 1'b1;
                            if (!active_reg)
                            begin
                                out_next.reply_kind = mrs_pkg::RK_READY;
                                active_next         = 1'b1;
                                peer_next           = q_item.arg[15:0];
                                armed_next          = 1'b1;
                                ticks_next          = cfg.timeout_ticks;
                            end
                            else
                            begin
                                out_next.reply_kind = mrs_pkg::RK_BUSY;
                            end
                        end
                        mrs_pkg::OP_PARAM:
                        begin
                            armed_next = 1'b1;
                            ticks_next = cfg.timeout_ticks;
                        end
                        mrs_pkg::OP_END:
                        begin
                            out_load              = 1'b1;
                            out_next.reply_kind   = mrs_pkg::RK_HEADER;
                            out_next.peer_address = peer_reg;
                            out_next.reply_value  = {1'b0, count_reg};
                            out_next.last_of_run  = (stored == '0);
                            drain_len_next        = stored;
                            drain_idx_next        = '0;
                            drain_peer_next       = peer_reg;
                            if (stored != '0)
                            begin
                                state_next = S_READ;
                            end
                            active_next = 1'b0;
                            peer_next   = '0;
                            count_next  = '0;
                            bsum_next   = '0;
                            psum_next   = '0;
                            armed_next  = 1'b0;
                            ticks_next  = '0;
                        end
                        mrs_pkg::OP_CONTINUE:
                        begin
                            if (count_reg != 16'hFFFF)
                            begin
                                count_next = count_reg + 16'd1;
                            end
                            bsum_next  = bs2;
                            psum_next  = ps1 + bs2;
                            armed_next = 1'b1;
                            ticks_next = cfg.timeout_ticks;
                        end
                        mrs_pkg::OP_CHECKSUM:
                        begin
                            if ({1'b0, chk1, chk2} != q_item.arg)
                            begin
                                out_load              = 1'b1;
                                out_next.reply_kind   = mrs_pkg::RK_WRONG;
                                out_next.peer_address = peer_reg;
                                out_next.reply_value  = q_item.arg;
                                out_next.last_of_run  = 1'b1;
                                active_next = 1'b0;
                                peer_next   = '0;
                                count_next  = '0;
                                bsum_next   = '0;
                                psum_next   = '0;
                                armed_next  = 1'b0;
                                ticks_next  = '0;
                            end
                            else
                            begin
                                armed_next = 1'b1;
                                ticks_next = cfg.timeout_ticks;
                            end
                        end
                        mrs_pkg::OP_TICK:
                        begin
                            if (armed_reg)
                            begin
                                if (ticks_reg <= 20'd1)
                                begin
                                    out_load              = 1'b1;
                                    out_next.reply_kind   = mrs_pkg::RK_TIMEOUT;
                                    out_next.peer_address = peer_reg;
                                    out_next.reply_value  = {1'b0, count_reg};
                                    out_next.last_of_run  = 1'b1;
                                    active_next = 1'b0;
                                    peer_next   = '0;
                                    count_next  = '0;
                                    bsum_next   = '0;
                                    psum_next   = '0;
                                    armed_next  = 1'b0;
                                    ticks_next  = '0;
                                end
                                else
                                begin
                                    ticks_next = ticks_reg - 20'd1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load              = 1'b1;
                    out_next.reply_kind   = mrs_pkg::RK_CHAR;
                    out_next.peer_address = drain_peer_reg;
                    out_next.reply_value  = {1'b0, rd_data_reg};
                    out_next.last_of_run  = (idx_inc == drain_len_reg);
                    drain_idx_next        = idx_inc;
                    state_next            = (idx_inc == drain_len_reg) ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            active_reg     <= 1'b0;
            peer_reg       <= '0;
            count_reg      <= '0;
            bsum_reg       <= '0;
            psum_reg       <= '0;
            armed_reg      <= 1'b0;
            ticks_reg      <= '0;
            drain_len_reg  <= '0;
            drain_idx_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            peer_reg       <= peer_next;
            count_reg      <= count_next;
            bsum_reg       <= bsum_next;
            psum_reg       <= psum_next;
            armed_reg      <= armed_next;
            ticks_reg      <= ticks_next;
            drain_len_reg  <= drain_len_next;
            drain_idx_reg  <= drain_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drain_peer_reg <= drain_peer_next;
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            text_mem[count_reg[mrs_pkg::BUF_IDX_W-1:0]] <= q_item.arg[15:0];
        end
        if (state_reg == S_READ)
        begin
            rd_data_reg <= text_mem[drain_idx_reg[mrs_pkg::BUF_IDX_W-1:0]];
        end
    end

    a_drain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (drain_idx_reg < drain_len_reg))
        else $error("drain index past stored characters");

    a_empty_sums: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (bsum_reg == '0 && psum_reg == '0))
        else $error("checksum sums set with no characters");

    a_timer_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> (ticks_reg == '0))
        else $error("ticks left while timer disarmed");

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: message receive session
// Directed table then randomised sessions: begin, characters, checksum, end
// and timer ticks under several register settings. Every accepted item
// updates a session predictor, and every popped reply is compared field by
// field with the oldest predicted reply.
// ----------------------------------------------------------------------------

module testbench;

    import mrs_pkg::*;

    localparam int          CYCLE_LIMIT   = 1500000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          HOLD_CYCLES   = 200;
    localparam logic [2:0]  CMD_SPARE_6   = 3'd6;
    localparam logic [2:0]  CMD_SPARE_7   = 3'd7;

    typedef enum logic [1:0] {BY_MODEL, WITH_CHK, TYPED} row_check_t;

    typedef struct packed {
        req_item_t   item;
        row_check_t  check;
        reply_kind_t kind;
        logic [15:0] peer;
        logic [16:0] value;
    } plan_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    push;
    logic                    full;
    req_item_t               req;
    logic                    empty;
    logic                    pop;
    rsp_item_t               rsp;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // session predictor
    logic                    sess_open;
    logic [15:0]             sess_peer;
    logic [15:0]             text_buf [BUF_CHARS];
    logic [15:0]             n_chars;
    logic [7:0]              byte_total;
    logic [7:0]              prefix_total;
    logic                    timer_on;
    logic [19:0]             ticks_remaining;
    logic [19:0]             timeout_reg;
    logic [15:0]             own_reg;

    rsp_item_t               replies_due [$];
    plan_row_t               plan [$];
    logic                    typed_pending = 1'b0;
    rsp_item_t               typed_reply;
    logic                    steady = 1'b0;
    logic                    hold_off_req = 1'b0;
    int unsigned             mismatches = 0;
    int unsigned             cycle_count;

    message_receive_session uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] session_checksum();
        logic [7:0] lo;
        logic [7:0] hi;
        lo = byte_total + 8'd1;
        hi = prefix_total + {n_chars[6:0], 1'b0};
        return {hi, lo};
    endfunction

    function automatic req_item_t req_of(input logic [2:0] cmd, input logic [15:0] caller,
                                         input logic [15:0] chr, input logic [16:0] chk);
        req_item_t it;
        it.cmd               = cmd;
        it.caller_address    = caller;
        it.char_code         = chr;
        it.expected_checksum = chk;
        return it;
    endfunction

    function automatic req_item_t random_req(input logic [2:0] cmd);
        return req_of(cmd, 16'($urandom), 16'($urandom), 17'($urandom_range(0, 99999)));
    endfunction

    task automatic emit(input reply_kind_t kind, input logic [15:0] peer,
                        input logic [16:0] value, input logic last);
        rsp_item_t r;
        r.reply_kind     = kind;
        r.peer_address   = peer;
        r.reply_value    = value;
        r.device_address = own_reg;
        r.last_of_run    = last;
        if (!typed_pending)
            replies_due.push_back(r);
    endtask

    task automatic close_session();
        sess_open       = 1'b0;
        sess_peer       = '0;
        n_chars         = '0;
        byte_total      = '0;
        prefix_total    = '0;
        timer_on        = 1'b0;
        ticks_remaining = '0;
    endtask

    task automatic rearm_timer();
        timer_on        = 1'b1;
        ticks_remaining = timeout_reg;
    endtask

    task automatic advance_session(input req_item_t it);
        int unsigned stored;
        logic [15:0] ch;
        ch = it.char_code;
        case (it.cmd)
            CMD_BEGIN:
                if (!sess_open)
                begin
                    sess_open = 1'b1;
                    sess_peer = it.caller_address;
                    emit(RK_READY, sess_peer, '0, 1'b1);
                    rearm_timer();
                end
                else
                    emit(RK_BUSY, it.caller_address, '0, 1'b1);
            CMD_PARAM:
                rearm_timer();
            CMD_END:
            begin
                stored = (n_chars < BUF_CHARS) ? n_chars : BUF_CHARS;
                emit(RK_HEADER, sess_peer, {1'b0, n_chars}, stored == 0);
                for (int i = 0; i < stored; i++)
                    emit(RK_CHAR, sess_peer, {1'b0, text_buf[i]}, i == stored - 1);
                close_session();
            end
            CMD_CONTINUE:
            begin
                if (n_chars < BUF_CHARS)
                    text_buf[n_chars[BUF_IDX_W-1:0]] = ch;
                if (n_chars != 16'hFFFF)
                    n_chars++;
                byte_total   = byte_total + ch[15:8];
                prefix_total = prefix_total + byte_total;
                byte_total   = byte_total + ch[7:0];
                prefix_total = prefix_total + byte_total;
                rearm_timer();
            end
            CMD_CHECKSUM:
                if ({1'b0, session_checksum()} != it.expected_checksum)
                begin
                    emit(RK_WRONG, sess_peer, it.expected_checksum, 1'b1);
                    close_session();
                end
                else
                    rearm_timer();
            CMD_TICK:
                if (timer_on)
                begin
                    if (ticks_remaining <= 20'd1)
                    begin
                        emit(RK_TIMEOUT, sess_peer, {1'b0, n_chars}, 1'b1);
                        close_session();
                    end
                    else
                        ticks_remaining--;
                end
            default: ;
        endcase
    endtask

    task automatic send_item(input req_item_t it);
        int unsigned gap;
        push <= 1'b1;
        req  <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        advance_session(it);
        if (typed_pending)
        begin
            replies_due.push_back(typed_reply);
            typed_pending = 1'b0;
        end
        gap = pick_gap();
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic program_regs(input logic [19:0] ticks, input logic [15:0] addr);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_TIMEOUT_TICKS;
        cfg_data  <= ticks;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        timeout_reg = ticks;
        cfg_index <= CFG_OWN_ADDRESS;
        cfg_data  <= {4'h0, addr};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        own_reg = addr;
        cfg_valid <= 1'b0;
    endtask

    task automatic await_replies();
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_row(input logic [2:0] cmd, input logic [15:0] caller,
                           input logic [15:0] chr, input logic [16:0] chk,
                           input row_check_t check, input reply_kind_t kind,
                           input logic [15:0] peer, input logic [16:0] value);
        plan_row_t row;
        row.item  = req_of(cmd, caller, chr, chk);
        row.check = check;
        row.kind  = kind;
        row.peer  = peer;
        row.value = value;
        plan.push_back(row);
    endtask

    // session that opens with a begin, random content; returns items that count
    task automatic random_session(output int unsigned n);
        int unsigned len;
        int unsigned pick;
        req_item_t   it;
        n   = 0;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
        send_item(random_req(CMD_BEGIN));
        n++;
        for (int k = 0; k < len; k++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                it = random_req(CMD_CONTINUE);
            else if (pick < 16)
                it = random_req(CMD_PARAM);
            else if (pick < 18)
                it = random_req(CMD_TICK);
            else
                it = random_req(CMD_BEGIN);
            send_item(it);
            n++;
        end
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            it = random_req(CMD_CHECKSUM);
            it.expected_checksum = {1'b0, session_checksum()};
            send_item(it);
            n++;
        end
        else if (pick < 8)
        begin
            send_item(random_req(CMD_CHECKSUM));
            n++;
        end
        if (pick < 5 || pick == 8)
        begin
            send_item(random_req(CMD_END));
            n++;
        end
    endtask

    task automatic random_traffic(input int unsigned budget);
        int unsigned sent;
        int unsigned n;
        int unsigned burst;
        logic [2:0]  cmd;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                random_session(n);
                sent += n;
            end
            else
            begin
                cmd   = 3'($urandom_range(0, 7));
                burst = (cmd == CMD_TICK) ? $urandom_range(1, 6) : 1;
                repeat (burst) send_item(random_req(cmd));
                if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7)
                    sent += burst;
            end
        end
        push <= 1'b0;
    endtask

    task automatic report(input string field, input logic [16:0] want, input logic [16:0] got);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t: %s expected %h got %h", $time, field, want, got);
    endtask

    task automatic check_reply(input rsp_item_t got);
        rsp_item_t want;
        if (replies_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: reply with none expected, expected none got %h", $time, got);
        end
        else
        begin
            want = replies_due.pop_front();
            if (got.reply_kind !== want.reply_kind)
                report("reply_kind", want.reply_kind, got.reply_kind);
            if (got.peer_address !== want.peer_address)
                report("peer_address", want.peer_address, got.peer_address);
            if (got.reply_value !== want.reply_value)
                report("reply_value", want.reply_value, got.reply_value);
            if (got.device_address !== want.device_address)
                report("device_address", want.device_address, got.device_address);
            if (got.last_of_run !== want.last_of_run)
                report("last_of_run", want.last_of_run, got.last_of_run);
        end
    endtask

    always @(posedge clk)
        if (rst_n && !empty && pop)
            check_reply(rsp);

    // result side: random gaps, plus one long hold-off on request
    initial
    begin
        int unsigned pop_wait;
        pop_wait = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (pop_wait != 0)
            begin
                pop <= 1'b0;
                pop_wait--;
            end
            else
            begin
                pop <= 1'b1;
                pop_wait = pick_gap();
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: cycle limit reached", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        req_item_t it;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_TIMEOUT_TICKS;
        cfg_data  <= '0;
        timeout_reg = TIMEOUT_TICKS_RESET;
        own_reg     = OWN_ADDRESS_RESET;
        close_session();

        //      cmd           caller    char      checksum    check     kind        peer      value
        add_row(CMD_TICK,     16'h0000, 16'h0000, 17'd0,      BY_MODEL, RK_READY,   16'h0000, 17'd0);
        add_row(CMD_CHECKSUM, 16'h0000, 16'h0000, 17'd1,      BY_MODEL, RK_READY,   16'h0000, 17'd0);
        add_row(CMD_END,      16'h0000, 16'h0000, 17'd0,      TYPED,    RK_HEADER,  16'h0000, 17'd0);
        add_row(CMD_BEGIN,    16'hFFFF, 16'h0000, 17'd0,      TYPED,    RK_READY,   16'hFFFF, 17'd0);
        add_row(CMD_BEGIN,    16'h0000, 16'hFFFF, 17'd0,      TYPED,    RK_BUSY,    16'h0000, 17'd0);
        add_row(CMD_PARAM,    16'h5A5A, 16'hA5A5, 17'd99999,  BY_MODEL, RK_READY,   16'h0000, 17'd0);
        add_row(CMD_CONTINUE, 16'h0000, 16'hFFFF, 17'd0,      BY_MODEL, RK_READY,   16'h0000, 17'd0);
        add_row(CMD_CONTINUE, 16'hFFFF, 16'h0000, 17'd0,      BY_MODEL, RK_READY,   16'h0000, 17'd0);
        add_row(CMD_CONTINUE, 16'h0000, 16'h8001, 17'd0,      BY_MODEL, RK_READY,   16'h0000, 17'd0);
        add_row(CMD_CHECKSUM, 16'h0000, 16'h0000, 17'd0,      WITH_CHK, RK_READY,   16'h0000, 17'd0);
        add_row(CMD_TICK,     16'h0000, 16'h0000, 17'd0,      BY_MODEL, RK_READY,   16'h0000, 17'd0);
        add_row(CMD_CHECKSUM, 16'h0000, 16'h0000, 17'd99999,  TYPED,    RK_WRONG,   16'hFFFF, 17'd99999);
        add_row(CMD_END,      16'h0000, 16'h0000, 17'd0,      TYPED,    RK_HEADER,  16'h0000, 17'd0);
        add_row(CMD_BEGIN,    16'h1234, 16'h0000, 17'd0,      TYPED,    RK_READY,   16'h1234, 17'd0);
        add_row(CMD_CONTINUE, 16'h0000, 16'h00FF, 17'd0,      BY_MODEL, RK_READY,   16'h0000, 17'd0);
        add_row(CMD_CONTINUE, 16'h0000, 16'hFF00, 17'd0,      BY_MODEL, RK_READY,   16'h0000, 17'd0);
        add_row(CMD_CONTINUE, 16'h0000, 16'h0000, 17'd0,      BY_MODEL, RK_READY,   16'h0000, 17'd0);
        add_row(CMD_END,      16'h0000, 16'h0000, 17'd0,      BY_MODEL, RK_READY,   16'h0000, 17'd0);
        add_row(CMD_CHECKSUM, 16'h0000, 16'h0000, 17'd0,      TYPED,    RK_WRONG,   16'h0000, 17'd0);
        add_row(CMD_SPARE_6,  16'hFFFF, 16'hFFFF, 17'h1FFFF,  BY_MODEL, RK_READY,   16'h0000, 17'd0);
        add_row(CMD_SPARE_7,  16'hFFFF, 16'hFFFF, 17'h1FFFF,  BY_MODEL, RK_READY,   16'h0000, 17'd0);
        add_row(CMD_CONTINUE, 16'h0000, 16'hABCD, 17'd0,      BY_MODEL, RK_READY,   16'h0000, 17'd0);
        add_row(CMD_PARAM,    16'h0000, 16'h0000, 17'd0,      BY_MODEL, RK_READY,   16'h0000, 17'd0);
        add_row(CMD_END,      16'h0000, 16'h0000, 17'd0,      BY_MODEL, RK_READY,   16'h0000, 17'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset register values
        foreach (plan[r])
        begin
            it = plan[r].item;
            if (plan[r].check == WITH_CHK)
                it.expected_checksum = {1'b0, session_checksum()};
            if (plan[r].check == TYPED)
            begin
                typed_reply.reply_kind     = plan[r].kind;
                typed_reply.peer_address   = plan[r].peer;
                typed_reply.reply_value    = plan[r].value;
                typed_reply.device_address = OWN_ADDRESS_RESET;
                typed_reply.last_of_run    = 1'b1;
                typed_pending = 1'b1;
            end
            send_item(it);
        end
        push <= 1'b0;

        // fastest timer, top address
        await_replies();
        program_regs(20'd1, 16'hFFFF);
        random_traffic(30);

        // short timer; receiver holds off while begins pile up
        await_replies();
        program_regs(20'd4, 16'($urandom));
        hold_off_req = 1'b1;
        repeat (8) send_item(random_req(CMD_BEGIN));
        send_item(random_req(CMD_END));
        random_traffic(30);

        // longest timer, no idling for a stretch
        await_replies();
        program_regs(20'd1000000, 16'h0000);
        steady = 1'b1;
        random_traffic(15);
        steady = 1'b0;
        random_traffic(35);

        await_replies();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
